### hw/rtl/rpn_pkg.sv
// shared types and constants of the postfix expression evaluator
package rpn_pkg;

   // operator codes
   localparam logic [2:0] OPC_ADD = 3'd0;
   localparam logic [2:0] OPC_SUB = 3'd1;
   localparam logic [2:0] OPC_MUL = 3'd2;
   localparam logic [2:0] OPC_DIV = 3'd3;
   localparam logic [2:0] OPC_REM = 3'd4;
   localparam logic [2:0] OPC_POW = 3'd5;

   // token kind codes on the op field
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_APPLY = 1'b1;

   // status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_DIV0  = 3'd1;
   localparam logic [2:0] ST_UNDER = 3'd2;
   localparam logic [2:0] ST_OVER  = 3'd3;
   localparam logic [2:0] ST_LEFT  = 3'd4;

   typedef struct packed {
      logic               op;
      logic signed [31:0] value;
      logic [2:0]         operator_code;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic [2:0]         status;
   } rsp_type;

   // classified token kinds
   typedef enum logic [1:0] {
      KIND_PUSH = 2'd0,
      KIND_OPER = 2'd1,
      KIND_SKIP = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  code;
      logic [31:0] value;
      logic        last;
   } tok_type;

   typedef struct packed {
      logic        start;
      logic [2:0]  code;
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic        div0;
      logic [31:0] res;
   } alu_rsp_type;

endpackage

### hw/rtl/rpn_ram.sv
// generic single write port ram with registered read
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/rpn_front.sv
// token intake: classifies tokens and queues them for the stack engine
module rpn_front
   import rpn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    tok_valid,
   output tok_type tok,
   input  logic    tok_pop
);

   tok_type    slots_ff [2];
   tok_type    slot_in;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign tok_valid = (cnt_ff != 2'd0);
   assign tok       = slots_ff[rd_ptr_ff];

   // classify the incoming token
   always_comb begin
      slot_in.code  = req_data.operator_code;
      slot_in.value = req_data.value;
      slot_in.last  = req_data.last;
      if (req_data.op == OP_PUSH) begin
         slot_in.kind = KIND_PUSH;
      end else if (req_data.operator_code <= OPC_POW) begin
         slot_in.kind = KIND_OPER;
      end else begin
         slot_in.kind = KIND_SKIP;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= slot_in;
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (tok_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, tok_pop};
      end
   end

   // queue never holds more than two tokens and never pops when empty
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= 2'd2) && !(tok_pop && (cnt_ff == 2'd0)))
      else $error("token queue count out of range");

endmodule

### hw/rtl/rpn_alu.sv
// multi-cycle arithmetic unit: add, sub, mul, iterative divide, square-and-multiply power
module rpn_alu
   import rpn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   typedef enum logic [3:0] {
      A_IDLE = 4'b0001,
      A_DIV  = 4'b0010,
      A_POW  = 4'b0100,
      A_DONE = 4'b1000
   } alu_state_type;

   alu_state_type state_ff, state_in;
   logic [2:0]  code_ff, code_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] sq_ff, sq_in;
   logic [31:0] exp_ff, exp_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] mb_ff, mb_in;
   logic        na_ff, na_in;
   logic        nb_ff, nb_in;
   logic        div0_ff, div0_in;
   logic [4:0]  iter_ff, iter_in;

   logic [32:0] shifted;
   logic [32:0] diff;
   logic [31:0] prod_acc;
   logic [31:0] prod_sq;
   logic [31:0] prod_ab;

   assign prod_ab  = req.a * req.b;
   assign prod_acc = acc_ff * sq_ff;
   assign prod_sq  = sq_ff * sq_ff;
   assign shifted  = {rem_ff, quo_ff[31]};
   assign diff     = shifted - {1'b0, mb_ff};

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      acc_in   = acc_ff;
      sq_in    = sq_ff;
      exp_in   = exp_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      mb_in    = mb_ff;
      na_in    = na_ff;
      nb_in    = nb_ff;
      div0_in  = div0_ff;
      iter_in  = iter_ff;
      case (state_ff)
         A_IDLE: begin
            if (req.start) begin
               code_in  = req.code;
               na_in    = req.a[31];
               nb_in    = req.b[31];
               div0_in  = 1'b0;
               state_in = A_DONE;
               case (req.code)
                  OPC_ADD: acc_in = req.a + req.b;
                  OPC_SUB: acc_in = req.a - req.b;
                  OPC_MUL: acc_in = prod_ab;
                  OPC_DIV, OPC_REM: begin
                     if (req.b == 32'd0) begin
                        div0_in = 1'b1;
                     end else begin
                        quo_in   = req.a[31] ? (32'd0 - req.a) : req.a;
                        mb_in    = req.b[31] ? (32'd0 - req.b) : req.b;
                        rem_in   = 32'd0;
                        iter_in  = 5'd0;
                        state_in = A_DIV;
                     end
                  end
                  OPC_POW: begin
                     if (req.b[31]) begin
                        // negative exponent special cases
                        if (req.a == 32'd1) begin
                           acc_in = 32'd1;
                        end else if (req.a == 32'hFFFF_FFFF) begin
                           acc_in = req.b[0] ? 32'hFFFF_FFFF : 32'd1;
                        end else begin
                           acc_in  = 32'd0;
                           div0_in = (req.a == 32'd0);
                        end
                     end else begin
                        acc_in   = 32'd1;
                        sq_in    = req.a;
                        exp_in   = req.b;
                        state_in = A_POW;
                     end
                  end
                  default: acc_in = 32'd0;
               endcase
            end
         end
         A_DIV: begin
            // one restoring step per cycle
            if (!diff[32]) begin
               rem_in = diff[31:0];
            end else begin
               rem_in = shifted[31:0];
            end
            quo_in  = {quo_ff[30:0], ~diff[32]};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd31) begin
               state_in = A_DONE;
            end
         end
         A_POW: begin
            // one exponent bit per cycle
            if (exp_ff == 32'd0) begin
               state_in = A_DONE;
            end else begin
               if (exp_ff[0]) begin
                  acc_in = prod_acc;
               end
               sq_in  = prod_sq;
               exp_in = {1'b0, exp_ff[31:1]};
            end
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      code_ff <= code_in;
      acc_ff  <= acc_in;
      sq_ff   <= sq_in;
      exp_ff  <= exp_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      mb_ff   <= mb_in;
      na_ff   <= na_in;
      nb_ff   <= nb_in;
      div0_ff <= div0_in;
      iter_ff <= iter_in;
   end

   // result select with sign fix for divide and remainder
   always_comb begin
      rsp.done = (state_ff == A_DONE);
      rsp.div0 = div0_ff;
      case (code_ff)
         OPC_DIV: rsp.res = (na_ff != nb_ff) ? (32'd0 - quo_ff) : quo_ff;
         OPC_REM: rsp.res = na_ff ? (32'd0 - rem_ff) : rem_ff;
         default: rsp.res = acc_ff;
      endcase
   end

   // done lasts exactly one cycle
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      (state_ff == A_DONE) |=> (state_ff == A_IDLE))
      else $error("alu done held longer than one cycle");

endmodule

### hw/rtl/rpn_back.sv
// stack engine: executes queued tokens on the operand stack and emits results
module rpn_back
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    tok_valid,
   input  tok_type tok,
   output logic    tok_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_CALC = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] top_ff, top_in;
   logic [2:0]  err_ff, err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic          we;
   logic [CW-1:0] waddr_full;
   logic [CW-1:0] raddr_full;
   logic [31:0]   rdata;
   alu_req_type   alu_req;
   alu_rsp_type   alu_rsp;

   // entries below the top live in ram, the top in a register
   assign waddr_full = count_ff - CW'(1);
   assign raddr_full = count_ff - CW'(2);

   rpn_ram #(
      .WIDTH(32),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock(clock),
      .we(we),
      .waddr(waddr_full[AW-1:0]),
      .wdata(top_ff),
      .raddr(raddr_full[AW-1:0]),
      .rdata(rdata)
   );

   rpn_alu u_alu (
      .clock(clock),
      .reset(reset),
      .req(alu_req),
      .rsp(alu_rsp)
   );

   // token sequencer
   always_comb begin
      logic       go_read;
      logic [2:0] status;
      go_read      = 1'b0;
      status       = err_ff;
      state_in     = state_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      err_in       = err_ff;
      tok_pop      = 1'b0;
      we           = 1'b0;
      alu_req      = '{start: 1'b0, code: tok.code, a: rdata, b: top_ff};
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (tok_valid) begin
               if (err_ff == ST_OK) begin
                  case (tok.kind)
                     KIND_PUSH: begin
                        if (count_ff >= CW'(STACK_DEPTH)) begin
                           err_in = ST_OVER;
                        end else begin
                           we       = (count_ff != '0);
                           top_in   = tok.value;
                           count_in = count_ff + CW'(1);
                        end
                     end
                     KIND_OPER: begin
                        if (count_ff < CW'(2)) begin
                           err_in = ST_UNDER;
                        end else begin
                           go_read = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
               if (go_read) begin
                  state_in = S_READ;
               end else if (tok.last) begin
                  state_in = S_FIN;
               end else begin
                  tok_pop = 1'b1;
               end
            end
         end
         S_READ: begin
            alu_req.start = 1'b1;
            state_in      = S_CALC;
         end
         S_CALC: begin
            if (alu_rsp.done) begin
               if (alu_rsp.div0) begin
                  err_in = ST_DIV0;
               end else begin
                  count_in = count_ff - CW'(1);
                  top_in   = alu_rsp.res;
               end
               if (tok.last) begin
                  state_in = S_FIN;
               end else begin
                  tok_pop  = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (err_ff == ST_OK) begin
                  if (count_ff == '0) begin
                     status = ST_UNDER;
                  end else if (count_ff > CW'(1)) begin
                     status = ST_LEFT;
                  end
               end
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = status;
               rsp_data_in.result = (status == ST_OK) ? top_ff : 32'd0;
               count_in           = '0;
               err_in             = ST_OK;
               tok_pop            = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff      <= top_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stack count stays within the configured depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // a failed expression always reports a zero result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != ST_OK)) |-> (rsp_data_ff.result == 32'd0))
      else $error("nonzero result with error status");

   // the alu is only started with at least two operands on the stack
   a_alu_operands: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> (count_ff >= CW'(2)))
      else $error("alu started with fewer than two operands");

endmodule

### hw/rtl/postfix_expression_evaluator.sv
// Postfix (RPN) evaluator on a signed 32-bit operand stack of STACK_DEPTH entries. Each req
// transaction is one token; the token marked last yields one rsp transaction with the top of
// the stack and a status (0 ok, 1 divide by zero, 2 underflow, 3 overflow, 4 leftover
// operands; result is 0 on any error), after which the stack is empty again. A two-entry
// token queue decouples intake from execution. A push, a skipped token or a token after an
// error is handled in the idle state; add, subtract, multiply, a divide by zero and a power
// with a negative exponent pass the read and calc states, the alu going straight to done;
// divide and remainder use the restoring divider that resolves one quotient bit per cycle;
// power uses one square-and-multiply step per significant exponent bit. A last token then
// emits its result from the fin state, waiting while an earlier result waits on rsp_ready.
// The stack memory needs no initialization; the block accepts tokens right after reset.
module postfix_expression_evaluator
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    tok_valid;
   tok_type tok;
   logic    tok_pop;

   rpn_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .tok_valid(tok_valid),
      .tok(tok),
      .tok_pop(tok_pop)
   );

   rpn_back #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .tok_valid(tok_valid),
      .tok(tok),
      .tok_pop(tok_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

### bench/tb_postfix_expression_evaluator.sv
// self-checking testbench of the postfix expression evaluator
module tb_postfix_expression_evaluator;
   import rpn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;

   // evaluator state mirror and queue of expected results
   class rpn_scoreboard;
      logic [31:0] stack[DEPTH];
      int          depth_used;
      logic [2:0]  sticky;
      rsp_type     pending[$];
      int          errors;
      int          results_seen;

      function new();
         depth_used = 0;
         sticky = ST_OK;
         errors = 0;
         results_seen = 0;
      endfunction

      function logic [31:0] raise(logic [31:0] base, logic [31:0] ex, inout logic [2:0] err);
         logic [31:0] acc;
         logic [31:0] sq;
         acc = 1;
         sq = base;
         if (ex[31]) begin
            if (base == 32'd1) return 1;
            if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
            if (base == 0) err = ST_DIV0;
            return 0;
         end
         while (ex != 0) begin
            if (ex[0]) acc = acc * sq;
            sq = sq * sq;
            ex = ex >> 1;
         end
         return acc;
      endfunction

      function logic [31:0] compute(logic [2:0] code, logic [31:0] a, logic [31:0] b,
                                    inout logic [2:0] err);
         logic [31:0] ma;
         logic [31:0] mb;
         logic [31:0] q;
         logic [31:0] r;
         ma = a[31] ? -a : a;
         mb = b[31] ? -b : b;
         case (code)
            OPC_ADD: return a + b;
            OPC_SUB: return a - b;
            OPC_MUL: return a * b;
            OPC_DIV, OPC_REM: begin
               if (b == 0) begin
                  err = ST_DIV0;
                  return 0;
               end
               q = ma / mb;
               r = ma % mb;
               if (code == OPC_DIV) return (a[31] != b[31]) ? -q : q;
               return a[31] ? -r : r;
            end
            default: return raise(a, b, err);
         endcase
      endfunction

      // note an accepted input transaction
      function void note_token(req_type t);
         logic [2:0]  err;
         logic [31:0] res;
         rsp_type     e;
         if (sticky == ST_OK) begin
            if (t.op == OP_PUSH) begin
               if (depth_used >= DEPTH) sticky = ST_OVER;
               else begin
                  stack[depth_used] = t.value;
                  depth_used++;
               end
            end else if (t.operator_code <= OPC_POW) begin
               if (depth_used < 2) sticky = ST_UNDER;
               else begin
                  err = ST_OK;
                  res = compute(t.operator_code, stack[depth_used-2], stack[depth_used-1], err);
                  if (err != ST_OK) sticky = err;
                  else begin
                     depth_used--;
                     stack[depth_used-1] = res;
                  end
               end
            end
         end
         if (t.last) begin
            e.status = sticky;
            e.result = 0;
            if (sticky == ST_OK) begin
               if (depth_used == 0) e.status = ST_UNDER;
               else if (depth_used > 1) e.status = ST_LEFT;
               else e.result = stack[0];
            end
            pending.push_back(e);
            depth_used = 0;
            sticky = ST_OK;
         end
      endfunction

      // check one result transaction
      function void check_result(rsp_type got);
         rsp_type e;
         results_seen++;
         if (pending.size() == 0) begin
            $error("unexpected result: result %0d status %0d", got.result, got.status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.result !== e.result) begin
            $error("result: expected %0d actual %0d", e.result, got.result);
            errors++;
         end
         if (got.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;

   rpn_scoreboard board = new();
   int  tokens_sent = 0;
   bit  drain_hold = 0;
   bit  calm = 0;
   bit  drained_once = 0;

   postfix_expression_evaluator #(.STACK_DEPTH(DEPTH)) uut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // watchdog
   initial begin
      #400ms;
      $display("Test completed with failures");
      $finish;
   end

   // input transaction monitor
   always @(posedge clock)
      if (!reset && req_valid && req_ready) board.note_token(req_data);

   // result side: random stalls, one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
      rsp_ready <= !drain_hold && (calm || $urandom_range(99) >= 9);
   end

   initial begin
      @(posedge clock);
      wait (tokens_sent > 700);
      drain_hold = 1;
      repeat (3000) @(posedge clock);
      drain_hold = 0;
   end

   // offer one token, wait for acceptance; random idle cycles before it
   task automatic send(logic op, logic [31:0] v, logic [2:0] code, logic lst);
      req_type t;
      while (!calm && $urandom_range(99) < 9) begin
         req_valid <= 0;
         @(posedge clock);
      end
      t.op = op;
      t.value = v;
      t.operator_code = code;
      t.last = lst;
      req_valid <= 1;
      req_data <= t;
      do @(posedge clock); while (!req_ready);
      tokens_sent++;
   endtask

   // stop offering and wait until every expected result has come
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      wait (board.pending.size() == 0);
      @(posedge clock);
   endtask

   task automatic push(logic [31:0] v, logic lst = 0);
      send(OP_PUSH, v, 3'($urandom_range(7)), lst);
   endtask

   task automatic apply(logic [2:0] code, logic lst = 0);
      send(OP_APPLY, $urandom, code, lst);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom_range(7) - 3;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return $urandom_range(40);
         default: return $urandom;
      endcase
   endfunction

   // one random well-formed expression, sometimes broken
   task automatic random_expr();
      int n;
      int live;
      logic [2:0] code;
      n = $urandom_range(1, 6);
      live = 0;
      for (int i = 0; i < n; i++) begin
         push(pick_value());
         live++;
         if (live >= 2 && $urandom_range(1)) begin
            code = $urandom_range(9) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
            // mostly trade power for multiply to keep values varied
            if (code == OPC_POW && $urandom_range(3) != 0) begin
               apply(OPC_MUL);
            end else apply(code);
            if (code <= OPC_POW) live--;
         end
      end
      while (live > 1 && $urandom_range(9) != 0) begin
         code = 3'($urandom_range(5));
         apply(code);
         live--;
      end
      if ($urandom_range(9) == 0) apply(3'($urandom_range(5)), 1);
      else if ($urandom_range(9) == 0) push(pick_value(), 1);
      else apply(3'($urandom_range(7)), 1);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      calm = 1;
      // directed: every operator and the listed corner cases
      push(7); push(3); apply(OPC_ADD, 1);
      push(7); push(-3); apply(OPC_SUB, 1);
      push(32'h7FFF_FFFF); push(2); apply(OPC_MUL, 1);
      push(-7); push(2); apply(OPC_DIV, 1);
      push(-7); push(2); apply(OPC_REM, 1);
      push(5); push(0); apply(OPC_DIV, 1);
      push(5); push(0); apply(OPC_REM, 1);
      push(32'h8000_0000); push(-1); apply(OPC_DIV, 1);
      push(32'h8000_0000); push(-1); apply(OPC_REM, 1);
      push(0); push(0); apply(OPC_POW, 1);
      push(3); push(13); apply(OPC_POW, 1);
      push(-1); push(-3); apply(OPC_POW, 1);
      push(-1); push(-4); apply(OPC_POW, 1);
      push(1); push(32'h8000_0000); apply(OPC_POW, 1);
      push(0); push(-2); apply(OPC_POW, 1);
      push(5); push(-2); apply(OPC_POW, 1);
      push(2); push(32'h7FFF_FFFF); apply(OPC_POW, 1);
      push(4); apply(OPC_ADD); push(1, 1);
      push(4); push(5); apply(3'd6); apply(3'd7, 1);
      push(1); push(2, 1);
      apply(OPC_ADD, 1);
      push(32'h7FFF_FFFF, 1);
      // fill the stack to overflow, then exactly full and folded back
      for (int i = 0; i <= DEPTH; i++) push($urandom, i == DEPTH);
      for (int i = 0; i < DEPTH; i++) push(i);
      for (int i = 0; i < DEPTH - 1; i++) apply(OPC_ADD, i == DEPTH - 2);
      calm = 0;
      // random: stretches with and without idling; pause for drain midway
      while (tokens_sent < 1850) begin
         if (tokens_sent > 1200 && tokens_sent < 1400) calm = 1;
         else calm = 0;
         random_expr();
         if (!drained_once && tokens_sent > 1000) begin
            drained_once = 1;
            drain();
         end
      end
      drain();
      repeat (100) @(posedge clock);
      $display("covered %0d tokens and %0d expression results, incl. stack overflow",
               tokens_sent, board.results_seen);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
